### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the scheduler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/srtf_pkg.sv
// Package with constants, types and helpers of the scheduler core.
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int BURST_BITS = 16;
    localparam int TIME_BITS  = 20;

    localparam int ID_W    = 5;
    localparam int TALLY_W = 16;
    localparam int SLOT_W  = $clog2(MAX_TASKS);
    localparam int LEN_W   = $clog2(MAX_TASKS + 1);

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ROTATE,
        S_SERVE,
        S_ARRIVE,
        S_IDLE_TICK
    } state_t;

    typedef enum logic {
        ACT_ARRIVE = 1'b0,
        ACT_TICK   = 1'b1
    } action_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] burst_len;
        logic [4:0]  task_id;
    } in_data_t;

    typedef struct packed {
        logic [2:0]  pad;
        status_t     status;
        logic [15:0] switch_count;
        logic [19:0] finish_time;
        logic        finished;
        logic        dispatched;
        logic [4:0]  running_id;
    } out_data_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic rotate;
        logic serve;
        logic arrive;
        logic idle_tick;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic list_empty;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] t;
        t = id - ID_W'(1);
        return t[SLOT_W-1:0];
    endfunction

endpackage

### rtl/srtf_ctrl.sv
// Controller state machine that sequences arrivals and ticks.
`timescale 1ns / 1ps

module srtf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  srtf_pkg::dp_stat_t st,
    output srtf_pkg::dp_cmd_t  cmd,
    output logic              in_ready
);
    import srtf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!st.is_tick)
                begin
                    state_next = S_ARRIVE;
                end
                else if (st.list_empty)
                begin
                    state_next = S_IDLE_TICK;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = S_ROTATE;
                end
            end
            S_ROTATE:
            begin
                state_next = S_SERVE;
            end
            S_SERVE, S_ARRIVE, S_IDLE_TICK:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DECODE:
            begin
                cmd.scan_init = st.is_tick && !st.list_empty;
            end
            S_SCAN:
            begin
                cmd.scan_step = !st.scan_done;
            end
            S_ROTATE:
            begin
                cmd.rotate = 1'b1;
            end
            S_SERVE:
            begin
                cmd.serve = st.out_free;
            end
            S_ARRIVE:
            begin
                cmd.arrive = st.out_free;
            end
            S_IDLE_TICK:
            begin
                cmd.idle_tick = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/srtf_dp.sv
// Datapath with the ready list, per-task counters and the result register.
`timescale 1ns / 1ps

module srtf_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  srtf_pkg::dp_cmd_t  cmd,
    output srtf_pkg::dp_stat_t st,
    input  logic [23:0]       s_tdata,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata
);
    import srtf_pkg::*;

    logic [ID_W-1:0]       order_reg [MAX_TASKS];
    logic [ID_W-1:0]       order_next [MAX_TASKS];
    logic [BURST_BITS-1:0] rem_reg [MAX_TASKS];
    logic [BURST_BITS-1:0] rem_next [MAX_TASKS];
    logic [TALLY_W-1:0]    tally_reg [MAX_TASKS];
    logic [TALLY_W-1:0]    tally_next [MAX_TASKS];

    logic [LEN_W-1:0]      len_reg, len_next;
    logic [ID_W-1:0]       last_reg, last_next;
    logic [TIME_BITS-1:0]  tick_reg, tick_next;
    logic [LEN_W-1:0]      idx_reg, idx_next;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    logic [BURST_BITS-1:0] best_reg, best_next;
    action_t               action_reg, action_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [BURST_BITS-1:0] burst_reg, burst_next;
    logic                  out_valid_reg, out_valid_next;
    out_data_t             out_data_reg, out_data_next;

    in_data_t              in_data;
    logic [ID_W-1:0]       scan_id;
    logic [BURST_BITS-1:0] scan_rem;
    logic [ID_W-1:0]       head_id;
    logic [SLOT_W-1:0]     head_slot;
    logic [BURST_BITS-1:0] head_rem;
    logic [BURST_BITS-1:0] rem_dec;
    logic [TALLY_W-1:0]    tally_inc;
    logic                  disp;
    logic                  dup_hit;
    status_t               arrive_status;

    assign in_data   = in_data_t'(s_tdata);
    assign scan_id   = order_reg[idx_reg[SLOT_W-1:0]];
    assign scan_rem  = rem_reg[slot_of(scan_id)];
    assign head_id   = order_reg[0];
    assign head_slot = slot_of(head_id);
    assign head_rem  = rem_reg[head_slot];
    assign disp      = head_id != last_reg;
    assign rem_dec   = (head_rem != '0) ? head_rem - BURST_BITS'(1) : head_rem;
    assign tally_inc = (disp && tally_reg[head_slot] != TALLY_MAX)
                     ? tally_reg[head_slot] + TALLY_W'(1) : tally_reg[head_slot];

    assign st.is_tick    = action_reg == ACT_TICK;
    assign st.list_empty = len_reg == '0;
    assign st.scan_done  = idx_reg >= len_reg;
    assign st.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 48'(out_data_reg);

    always_comb
    begin
        dup_hit = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (LEN_W'(i) < len_reg && order_reg[i] == id_reg)
            begin
                dup_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (id_reg == '0 || id_reg > ID_W'(MAX_TASKS))
        begin
            arrive_status = ST_DUP;
        end
        else if (len_reg >= LEN_W'(MAX_TASKS))
        begin
            arrive_status = ST_FULL;
        end
        else if (dup_hit)
        begin
            arrive_status = ST_DUP;
        end
        else if (burst_reg == '0)
        begin
            arrive_status = ST_ZERO;
        end
        else
        begin
            arrive_status = ST_OK;
        end
    end

    always_comb
    begin
        logic [LEN_W:0] src;
        order_next     = order_reg;
        rem_next       = rem_reg;
        tally_next     = tally_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        tick_next      = tick_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        action_next    = action_reg;
        id_next        = id_reg;
        burst_next     = burst_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        src            = '0;

        if (cmd.load)
        begin
            action_next = action_t'(s_tuser);
            id_next     = in_data.task_id;
            burst_next  = in_data.burst_len[BURST_BITS-1:0];
        end

        if (cmd.scan_init)
        begin
            best_next = head_rem;
            pos_next  = '0;
            idx_next  = LEN_W'(1);
        end

        if (cmd.scan_step)
        begin
            if (scan_rem < best_reg)
            begin
                best_next = scan_rem;
                pos_next  = idx_reg[SLOT_W-1:0];
            end
            idx_next = idx_reg + LEN_W'(1);
        end

        if (cmd.rotate)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                if (LEN_W'(i) < len_reg)
                begin
                    src = (LEN_W+1)'(pos_reg) + (LEN_W+1)'(i);
                    if (src >= (LEN_W+1)'(len_reg))
                    begin
                        src = src - (LEN_W+1)'(len_reg);
                    end
                    order_next[i] = order_reg[src[SLOT_W-1:0]];
                end
            end
        end

        if (cmd.serve)
        begin
            tally_next[head_slot] = tally_inc;
            rem_next[head_slot]   = rem_dec;
            last_next             = head_id;
            tick_next             = tick_reg + TIME_BITS'(1);
            out_data_next         = '0;
            out_data_next.running_id = head_id;
            out_data_next.dispatched = disp;
            if (rem_dec == '0)
            begin
                for (int i = 0; i < MAX_TASKS - 1; i++)
                begin
                    order_next[i] = order_reg[i+1];
                end
                order_next[MAX_TASKS-1] = '0;
                len_next = len_reg - LEN_W'(1);
                out_data_next.finished    = 1'b1;
                out_data_next.finish_time = 20'(tick_reg + TIME_BITS'(1));
                out_data_next.switch_count = (tally_inc != '0)
                                           ? 16'(tally_inc - TALLY_W'(1)) : '0;
            end
            out_valid_next = 1'b1;
        end

        if (cmd.arrive)
        begin
            if (arrive_status == ST_OK)
            begin
                order_next[len_reg[SLOT_W-1:0]] = id_reg;
                len_next                        = len_reg + LEN_W'(1);
                rem_next[slot_of(id_reg)]       = burst_reg;
                tally_next[slot_of(id_reg)]     = '0;
            end
            out_data_next        = '0;
            out_data_next.status = arrive_status;
            out_valid_next       = 1'b1;
        end

        if (cmd.idle_tick)
        begin
            tick_next      = tick_reg + TIME_BITS'(1);
            out_data_next  = '0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            last_reg      <= '0;
            tick_reg      <= '0;
            idx_reg       <= '0;
            action_reg    <= ACT_ARRIVE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            last_reg      <= last_next;
            tick_reg      <= tick_next;
            idx_reg       <= idx_next;
            action_reg    <= action_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg    <= order_next;
        rem_reg      <= rem_next;
        tally_reg    <= tally_next;
        pos_reg      <= pos_next;
        best_reg     <= best_next;
        id_reg       <= id_next;
        burst_reg    <= burst_next;
        out_data_reg <= out_data_next;
    end

endmodule

### rtl/srtf_preemptive_scheduler_core.sv
// Top level of the shortest-remaining-time-first scheduler core.
// Arrive item: decode, then the arrive state checks it and registers its result.
// Tick with ready tasks: decode, scan of the list, rotate, then serve registers the result.
// Idle tick: decode, then the idle tick registers its result. The scan uses one shared compare.
// One item at a time; a waiting result sits in the output register while the next item is taken.
// rst_n clears the list, the last served task, the tick count and the output valid.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module srtf_preemptive_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id[4:0], burst_len[20:5], zero pad
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // running_id, dispatched, finished, finish_time,
                                   // switch_count, status, zero pad
);
    import srtf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t st;
    logic [6:0] cmd_bits;

    srtf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    srtf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign cmd_bits = cmd;

    `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd_bits))
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `ASSERT_NEXT(a_emit_loads_out, cmd.serve || cmd.arrive || cmd.idle_tick, m_tvalid)
    `ASSERT_ALWAYS(a_emit_needs_room, !(cmd.serve && m_tvalid && !m_tready))

endmodule

### sim/srtf_sched_checker.sv
// Checker for the scheduler core: predicts every result item and compares it on the output.
`timescale 1ns / 1ps

module srtf_sched_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id[4:0], burst_len[20:5], zero pad
    input  logic        s_tuser,   // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // running_id, dispatched, finished, finish_time,
                                   // switch_count, status, zero pad
    output int          fail_count,
    output int          outstanding
);
    import srtf_pkg::*;

    logic [ID_W-1:0]    ready_ids [MAX_TASKS];
    int                 list_len;
    logic [15:0]        time_left [MAX_TASKS];
    logic [TALLY_W-1:0] dispatch_count [MAX_TASKS];
    logic [ID_W-1:0]    last_served;
    logic [19:0]        tick_count;
    out_data_t          results_due [$];
    int                 mismatches = 0;

    assign fail_count = mismatches;

    function automatic out_data_t schedule_item(action_t act, logic [ID_W-1:0] id,
                                                logic [15:0] burst);
        out_data_t       r;
        logic            dup;
        int              pos;
        int              slot;
        int              i;
        logic [15:0]     best;
        logic [ID_W-1:0] pick;
        logic [ID_W-1:0] rot [MAX_TASKS];
        r = '0;
        if (act == ACT_ARRIVE)
        begin
            dup = 1'b0;
            for (i = 0; i < list_len; i++)
                if (ready_ids[i] == id)
                    dup = 1'b1;
            if (id == 0 || id > MAX_TASKS)
                r.status = ST_DUP;
            else if (list_len >= MAX_TASKS)
                r.status = ST_FULL;
            else if (dup)
                r.status = ST_DUP;
            else if (burst == 16'd0)
                r.status = ST_ZERO;
            else
            begin
                ready_ids[list_len] = id;
                list_len++;
                time_left[id - 1] = burst;
                dispatch_count[id - 1] = '0;
            end
            return r;
        end
        if (list_len == 0)
        begin
            tick_count++;
            return r;
        end
        // pick the earliest task with the least time left
        pos = 0;
        best = time_left[ready_ids[0] - 1];
        for (i = 1; i < list_len; i++)
        begin
            if (time_left[ready_ids[i] - 1] < best)
            begin
                best = time_left[ready_ids[i] - 1];
                pos = i;
            end
        end
        for (i = 0; i < list_len; i++)
            rot[i] = ready_ids[(pos + i) % list_len];
        for (i = 0; i < list_len; i++)
            ready_ids[i] = rot[i];
        pick = ready_ids[0];
        slot = pick - 1;
        r.running_id = pick;
        if (pick != last_served)
        begin
            r.dispatched = 1'b1;
            last_served = pick;
            if (dispatch_count[slot] != TALLY_MAX)
                dispatch_count[slot]++;
        end
        if (time_left[slot] != 16'd0)
            time_left[slot]--;
        if (time_left[slot] == 16'd0)
        begin
            r.finished = 1'b1;
            r.finish_time = tick_count + 20'd1;
            r.switch_count = (dispatch_count[slot] != '0) ? dispatch_count[slot] - 1'b1 : '0;
            for (i = 1; i < list_len; i++)
                ready_ids[i - 1] = ready_ids[i];
            list_len--;
            ready_ids[list_len] = '0;
        end
        tick_count++;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_data_t got;
        out_data_t want;
        out_data_t due;
        if (!rst_n)
        begin
            results_due.delete();
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                ready_ids[k] = '0;
                time_left[k] = '0;
                dispatch_count[k] = '0;
            end
            list_len = 0;
            last_served = '0;
            tick_count = '0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = out_data_t'(m_tdata);
                if (results_due.size() == 0)
                    flag_mismatch("unexpected item, running_id", 32'(got.running_id), 32'd0);
                else
                begin
                    want = results_due.pop_front();
                    if (got.running_id !== want.running_id)
                        flag_mismatch("running_id", 32'(got.running_id),
                                      32'(want.running_id));
                    if (got.dispatched !== want.dispatched)
                        flag_mismatch("dispatched", 32'(got.dispatched),
                                      32'(want.dispatched));
                    if (got.finished !== want.finished)
                        flag_mismatch("finished", 32'(got.finished), 32'(want.finished));
                    if (got.finish_time !== want.finish_time)
                        flag_mismatch("finish_time", 32'(got.finish_time),
                                      32'(want.finish_time));
                    if (got.switch_count !== want.switch_count)
                        flag_mismatch("switch_count", 32'(got.switch_count),
                                      32'(want.switch_count));
                    if (got.status !== want.status)
                        flag_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
            if (s_tvalid && s_tready)
            begin
                due = schedule_item(action_t'(s_tuser), s_tdata[4:0], s_tdata[20:5]);
                results_due = {results_due, due};
            end
            outstanding <= results_due.size();
        end
    end

endmodule

### sim/tb_srtf_preemptive_scheduler_core.sv
// Testbench top for the scheduler core: drives directed and random items, gives the verdict.
`timescale 1ns / 1ps

module tb_srtf_preemptive_scheduler_core;
    import srtf_pkg::*;

    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // task_id[4:0], burst_len[20:5], zero pad
    logic        s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // running_id, dispatched, finished, finish_time,
                            // switch_count, status, zero pad
    int          fail_count;
    int          outstanding;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          holds_done = 0;

    always #2 clk = ~clk;

    srtf_preemptive_scheduler_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    srtf_sched_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    task automatic offer(action_t act, logic [4:0] id, logic [15:0] burst);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, burst, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n_items, int idle_pct, int stall_pct, bit with_hold);
        int         count;
        int         pick;
        int         j;
        int         k;
        bit         hold_sent;
        logic [4:0] ids [16];
        logic [4:0] tmp;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        count = 0;
        hold_sent = 1'b0;
        while (count < n_items)
        begin
            if (with_hold && !hold_sent && count >= 100)
            begin
                hold_requests++;
                hold_sent = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick == 0)
            begin
                // offer every id once in shuffled order, then overflow the full list
                for (k = 0; k < 16; k++)
                    ids[k] = 5'(k + 1);
                for (k = 15; k > 0; k--)
                begin
                    j = $urandom_range(k);
                    tmp = ids[k];
                    ids[k] = ids[j];
                    ids[j] = tmp;
                end
                for (k = 0; k < 16; k++)
                    offer(ACT_ARRIVE, ids[k], 16'($urandom_range(1, 6)));
                offer(ACT_ARRIVE, 5'($urandom_range(1, 16)), 16'($urandom_range(1, 65535)));
                count += 17;
            end
            else if (pick < 39)
                offer(ACT_ARRIVE, 5'($urandom_range(1, 15)),
                      ($urandom_range(4) == 0) ? 16'($urandom_range(1, 40))
                                               : 16'($urandom_range(1, 8)));
            else if (pick < 89)
                offer(ACT_TICK, 5'($urandom), 16'($urandom));
            else if (pick < 93)
                offer(ACT_ARRIVE, ($urandom_range(1) != 0) ? 5'($urandom_range(17, 31)) : 5'd0,
                      16'($urandom));
            else if (pick < 96)
                offer(ACT_ARRIVE, 5'($urandom_range(1, 16)), 16'd0);
            else
                offer(ACT_ARRIVE, 5'd16, 16'($urandom));
            count++;
        end
        wait_results_done();
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_ARRIVE;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer(ACT_TICK, 5'd31, 16'hFFFF);
        offer(ACT_ARRIVE, 5'd0, 16'hFFFF);
        offer(ACT_ARRIVE, 5'd17, 16'h5555);
        offer(ACT_ARRIVE, 5'd31, 16'hAAAA);
        offer(ACT_ARRIVE, 5'd1, 16'd0);
        offer(ACT_ARRIVE, 5'd16, 16'hFFFF);
        offer(ACT_ARRIVE, 5'd1, 16'd3);
        offer(ACT_ARRIVE, 5'd1, 16'd5);
        offer(ACT_ARRIVE, 5'd2, 16'd1);
        offer(ACT_ARRIVE, 5'd3, 16'd1);
        offer(ACT_TICK, 5'd0, 16'd0);
        offer(ACT_TICK, 5'd0, 16'd0);
        offer(ACT_ARRIVE, 5'd3, 16'd2);
        offer(ACT_TICK, 5'd0, 16'd0);
        offer(ACT_ARRIVE, 5'd4, 16'd1);
        offer(ACT_TICK, 5'd0, 16'd0);
        offer(ACT_TICK, 5'd0, 16'd0);
        repeat (4)
            offer(ACT_TICK, 5'd0, 16'd0);
        offer(ACT_ARRIVE, 5'd5, 16'd2);
        offer(ACT_TICK, 5'd0, 16'd0);
        offer(ACT_TICK, 5'd0, 16'd0);
        wait_results_done();

        run_phase(425, 0, 0, 1'b1);
        run_phase(425, 62, 0, 1'b0);
        run_phase(425, 0, 62, 1'b0);
        run_phase(425, 11, 11, 1'b0);

        repeat (40)
            @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
